// ===== rtl/md5h_pkg.sv =====
// Shared types, constants and round tables of the MD5 stream hasher.
`timescale 1ns / 1ps

package md5h_pkg;

  typedef logic [31:0] word_t;

  localparam word_t IV_A = 32'h67452301;
  localparam word_t IV_B = 32'hEFCDAB89;
  localparam word_t IV_C = 32'h98BADCFE;
  localparam word_t IV_D = 32'h10325476;

  localparam logic [7:0] MARK_BYTE = 8'h80;

  // Working variables of one compression, carried as a group.
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } md5h_vars_t;

  function automatic word_t round_const(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] idx);
    logic [4:0] s;
    case ({idx[5:4], idx[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word used by a round (the result is taken modulo 16).
  function automatic logic [3:0] msg_index(input logic [5:0] idx);
    logic [3:0] g;
    case (idx[5:4])
      2'd0:    g = idx[3:0];
      2'd1:    g = 4'(idx[3:0] * 4'd5 + 4'd1);
      2'd2:    g = 4'(idx[3:0] * 4'd3 + 4'd5);
      default: g = 4'(idx[3:0] * 4'd7);
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/md5h_if.sv =====
// Valid/ready channel interfaces for message bytes and digest parts.
`timescale 1ns / 1ps

interface md5h_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       finish;

  modport source (output valid, data_byte, has_byte, finish, input ready);
  modport sink   (input valid, data_byte, has_byte, finish, output ready);
endinterface

interface md5h_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_part;
  logic        last_part;

  modport source (output valid, digest_part, last_part, input ready);
  modport sink   (input valid, digest_part, last_part, output ready);
endinterface

// ===== rtl/md5h_round.sv =====
// One MD5 round step: mixing function, four-way add, rotate, add.
`timescale 1ns / 1ps

module md5h_round import md5h_pkg::*; (
  input  md5h_vars_t  vars,
  input  word_t       msg_word,
  input  logic [5:0]  idx,
  output md5h_vars_t  vars_next
);

  word_t      f;
  word_t      sum;
  word_t      rot;
  logic [4:0] s;

  always_comb begin
    case (idx[5:4])
      2'd0:    f = vars.d ^ (vars.b & (vars.c ^ vars.d));
      2'd1:    f = vars.c ^ (vars.d & (vars.b ^ vars.c));
      2'd2:    f = vars.b ^ vars.c ^ vars.d;
      default: f = vars.c ^ (vars.b | ~vars.d);
    endcase
  end

  assign s   = rot_amount(idx);
  assign sum = vars.a + f + msg_word + round_const(idx);
  // s is never zero, so the right shift stays below 32
  assign rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));

  assign vars_next.a = vars.d;
  assign vars_next.d = vars.c;
  assign vars_next.c = vars.b;
  assign vars_next.b = vars.b + rot;

endmodule

// ===== rtl/md5_stream_hasher_unit.sv =====
// Top level of the MD5 stream hasher: byte buffer, padding and round sequencer.
`timescale 1ns / 1ps
//
//  channel  | dir | payload                          | transfer when
//  ---------+-----+----------------------------------+----------------------
//  in_ch    | in  | data_byte[7:0], has_byte, finish | valid && ready
//  out_ch   | out | digest_part[63:0], last_part     | valid && ready
//
//  A byte that does not fill the block and carries no finish is written
//  while the sequencer stays idle. The 64th byte of a block starts a
//  compression: a write, a read-ahead of the first message word, 64 rounds
//  on the single shared round unit (one per cycle) and a chain add.
//  A finish pads one byte per cycle up to the end of the block, compresses,
//  does so once more when the length no longer fits, then moves the digest
//  into the output register. in_ch.ready is high only while the sequencer
//  is idle. Bytes of the next message are taken while the two digest parts
//  still wait; the next finish holds in its last step until the output
//  register is free. Reset is synchronous; the block buffer memory is not
//  cleared, since every entry is written before a compression reads it.

module md5_stream_hasher_unit import md5h_pkg::*; (
  input logic             clk,
  input logic             rst,
  md5h_in_if.sink         in_ch,
  md5h_out_if.source      out_ch
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;  // read-ahead of the first message word
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;  // fold working vars into the chain
  localparam logic [2:0] S_PAD   = 3'd4;  // write marker, zeros and length
  localparam logic [2:0] S_FINAL = 3'd5;  // hand the digest to the output

  logic [2:0]  state;
  md5h_vars_t  chain;
  md5h_vars_t  vars;
  md5h_vars_t  vars_next;
  logic [63:0] bit_count;
  logic [5:0]  round_idx;
  logic [5:0]  pad_pos;
  logic        pad_active;
  logic        pad_marked;
  logic        pad_extra;    // current pad block is not the last one
  logic        fin_pending;  // finish seen with the block-filling byte

  // block buffer: 16 words, byte lanes little endian
  logic [31:0] mem [16];
  logic [31:0] rd_data;
  logic [3:0]  rd_addr;
  logic        wr_en;
  logic [5:0]  wr_pos;
  logic [7:0]  wr_byte;

  logic [63:0] out_data;
  logic [63:0] hold_data;
  logic        out_valid;
  logic        out_last;

  logic        in_xfer;
  logic        out_xfer;
  logic [5:0]  byte_pos;
  logic [5:0]  pad_start_pos;
  logic [7:0]  pad_byte;
  logic [7:0]  len_byte;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_valid && out_ch.ready;
  assign byte_pos = bit_count[8:3];

  assign in_ch.ready        = (state == S_IDLE);
  assign out_ch.valid       = out_valid;
  assign out_ch.digest_part = out_data;
  assign out_ch.last_part   = out_last;

  // first pad position: after this transfer's byte, if it carried one
  assign pad_start_pos = (state == S_IDLE && in_ch.has_byte) ? byte_pos + 6'd1 : byte_pos;

  assign len_byte = bit_count[{pad_pos[2:0], 3'b000} +: 8];

  always_comb begin
    if (!pad_marked) begin
      pad_byte = MARK_BYTE;
    end else if (!pad_extra && pad_pos[5:3] == 3'b111) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_pos  = byte_pos;
    wr_byte = in_ch.data_byte;
    rd_addr = msg_index(6'd0);
    unique case (state)
      S_IDLE: begin
        wr_en = in_xfer && in_ch.has_byte;
      end
      S_PAD: begin
        wr_en   = 1'b1;
        wr_pos  = pad_pos;
        wr_byte = pad_byte;
      end
      S_ROUND: begin
        rd_addr = msg_index(round_idx + 6'd1);
      end
      S_PREP, S_ADD, S_FINAL: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_pos[5:2]][{wr_pos[1:0], 3'b000} +: 8] <= wr_byte;
    end
    rd_data <= mem[rd_addr];
  end

  md5h_round u_round (
    .vars      (vars),
    .msg_word  (rd_data),
    .idx       (round_idx),
    .vars_next (vars_next)
  );

  // working variables and output payload
  always_ff @(posedge clk) begin
    if (state == S_PREP) begin
      vars <= chain;
    end else if (state == S_ROUND) begin
      vars <= vars_next;
    end
    if (state == S_FINAL && !out_valid) begin
      out_data  <= {chain.b, chain.a};
      hold_data <= {chain.d, chain.c};
    end else if (out_xfer && !out_last) begin
      out_data <= hold_data;
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      chain       <= '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
      bit_count   <= '0;
      round_idx   <= '0;
      pad_pos     <= '0;
      pad_active  <= 1'b0;
      pad_marked  <= 1'b0;
      pad_extra   <= 1'b0;
      fin_pending <= 1'b0;
      out_valid   <= 1'b0;
      out_last    <= 1'b0;
    end else begin
      if (out_xfer) begin
        if (out_last) begin
          out_valid <= 1'b0;
          out_last  <= 1'b0;
        end else begin
          out_last <= 1'b1;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_ch.has_byte) begin
              bit_count <= bit_count + 64'd8;
            end
            if (in_ch.has_byte && byte_pos == 6'd63) begin
              fin_pending <= in_ch.finish;
              state       <= S_PREP;
            end else if (in_ch.finish) begin
              pad_active <= 1'b1;
              pad_marked <= 1'b0;
              pad_pos    <= pad_start_pos;
              pad_extra  <= (pad_start_pos[5:3] == 3'b111);
              state      <= S_PAD;
            end
          end
        end
        S_PREP: begin
          round_idx <= '0;
          state     <= S_ROUND;
        end
        S_ROUND: begin
          round_idx <= round_idx + 6'd1;
          if (round_idx == 6'd63) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          chain.a <= chain.a + vars.a;
          chain.b <= chain.b + vars.b;
          chain.c <= chain.c + vars.c;
          chain.d <= chain.d + vars.d;
          if (pad_active && pad_extra) begin
            // length goes into one more block of zeros
            pad_extra <= 1'b0;
            pad_pos   <= '0;
            state     <= S_PAD;
          end else if (pad_active) begin
            state <= S_FINAL;
          end else if (fin_pending) begin
            fin_pending <= 1'b0;
            pad_active  <= 1'b1;
            pad_marked  <= 1'b0;
            pad_pos     <= pad_start_pos;
            pad_extra   <= (pad_start_pos[5:3] == 3'b111);
            state       <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_PAD: begin
          pad_marked <= 1'b1;
          pad_pos    <= pad_pos + 6'd1;
          if (pad_pos == 6'd63) begin
            state <= S_PREP;
          end
        end
        S_FINAL: begin
          if (!out_valid) begin
            out_valid  <= 1'b1;
            out_last   <= 1'b0;
            chain      <= '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
            bit_count  <= '0;
            pad_active <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/md5h_checker.sv =====
// Port-level checks of the MD5 stream hasher and their bind to the top level.
`timescale 1ns / 1ps

module md5h_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_finish,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_digest,
  input logic        out_last
);

  // the first digest part is always followed by the second
  a_second_part: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_last) |=> (out_valid && out_last))
    else $error("second digest part missing");

  // two parts per digest, then the output register drains
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_last) |=> !out_valid)
    else $error("output still valid after last part");

  a_first_part: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !out_last)
    else $error("digest starts with last part");

  // a finish transfer starts padding or a compression, so input is held off
  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_finish) |=> !in_ready)
    else $error("input ready right after finish");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_digest)))
    else $error("stalled digest part changed");

endmodule

bind md5_stream_hasher_unit md5h_checker u_md5h_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_finish  (in_ch.finish),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_digest (out_ch.digest_part),
  .out_last   (out_ch.last_part)
);
